// File: hw/rtl/atan_ra_pkg.sv
// ----------------------------------------------------------------------------
// atan_ra_pkg
// Shared types and constants for the rational-approximation arctangent core.
// ----------------------------------------------------------------------------
package atan_ra_pkg;

    // Field widths
    localparam int SLOPE_W = 32;
    localparam int ANGLE_W = 31;

    // Reduced argument |t| (Q30), quotient bits per divider
    localparam int T_W       = 30;
    localparam int U_W       = 28;   // t^2 in Q30 stays below 2^28 (|t| < sqrt2-1)
    localparam int ACC_W     = 36;   // Horner accumulators, Q24
    localparam int R_W       = 30;   // ratio P/Q, Q29
    localparam int D1_STEPS  = 30;
    localparam int D2_STEPS  = 30;
    localparam int H_STEPS   = 5;

    // Input register + reduction divider + square + Horner + ratio divider
    // + final multiply + output register
    localparam int ATAN_LAT = 1 + (D1_STEPS + 1) + 1 + H_STEPS + (D2_STEPS + 1) + 1 + 1;

    localparam logic [29:0] HALF_PI_Q29    = 30'd843314857;
    localparam logic [29:0] QUARTER_PI_Q29 = 30'd421657428;
    localparam logic [31:0] LOW_BAND_MAX   = 32'd27145;
    localparam logic [31:0] HIGH_BAND_MIN  = 32'd158218;
    localparam logic [31:0] ONE_Q16        = 32'd65536;

    // Q24 coefficients, rounded from nine fractional decimal digits
    localparam logic [63:0] DEC_HALF = 64'd500000000;
    localparam logic [63:0] DEC_ONE  = 64'd1000000000;

    localparam logic [ACC_W-1:0] NUM_COEF [H_STEPS] = '{
        ACC_W'((64'd16   << 24) + ((64'd153641298 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd268  << 24) + ((64'd425481955 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd1153 << 24) + ((64'd29351540  << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd1780 << 24) + ((64'd406316433 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd896  << 24) + ((64'd785974037 << 24) + DEC_HALF) / DEC_ONE)
    };

    localparam logic [ACC_W-1:0] DEN_COEF [H_STEPS] = '{
        ACC_W'((64'd58   << 24) + ((64'd956970508 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd536  << 24) + ((64'd265374031 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd1666 << 24) + ((64'd783814882 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd2079 << 24) + ((64'd334974445 << 24) + DEC_HALF) / DEC_ONE),
        ACC_W'((64'd896  << 24) + ((64'd785974037 << 24) + DEC_HALF) / DEC_ONE)
    };

    localparam logic [ACC_W-1:0] ONE_Q24 = ACC_W'(64'd1 << 24);

    typedef enum logic [1:0] {
        BAND_LOW,
        BAND_MID,
        BAND_HIGH
    } t_band;

    // Per-item control that travels alongside the datapath
    typedef struct packed {
        logic  neg;
        t_band band;
        logic  tneg;
    } t_side;

endpackage

// File: hw/rtl/arctangent_rational_approx_core.sv
// ----------------------------------------------------------------------------
// arctangent_rational_approx_core
// Pipelined atan(x): Q15.16 in, Q1.29 radians out, three-band reduction and
// a degree-4/degree-5 rational kernel.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals              Transfer
// input     in         start, i_slope       start high while busy low
// result    out        o_valid, o_angle     o_valid high, one cycle only
//
// One item may be taken every clock; busy is never raised.
// The pipeline holds two radix-2 dividers (reduction and P/Q ratio) of 31
// register stages each (set-up plus 30 quotient bits), plus the input register,
// squaring, 5 Horner stages, final multiply and output register.
// Synchronous active-low reset clears the valid chain only.
// The receiver cannot stall; results appear on o_valid without backpressure.
// ----------------------------------------------------------------------------
module arctangent_rational_approx_core
    import atan_ra_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic signed [SLOPE_W-1:0] i_slope,
    output logic                      busy,
    output logic                      o_valid,
    output logic signed [ANGLE_W-1:0] o_angle
);

    // Input register
    logic        r_in_vld;
    logic        r_in_neg;
    logic [31:0] r_in_a;

    // Reduction divider: index 0 holds the initial partial remainder
    logic        r_d1_vld  [0:D1_STEPS];
    t_side       r_d1_side [0:D1_STEPS];
    logic [31:0] r_d1_rem  [0:D1_STEPS];
    logic [29:0] r_d1_low  [0:D1_STEPS];
    logic [29:0] r_d1_quo  [0:D1_STEPS];
    logic [31:0] r_d1_div  [0:D1_STEPS];
    t_side       n_d1_side [0:D1_STEPS];
    logic [31:0] n_d1_rem  [0:D1_STEPS];
    logic [29:0] n_d1_low  [0:D1_STEPS];
    logic [29:0] n_d1_quo  [0:D1_STEPS];
    logic [31:0] n_d1_div  [0:D1_STEPS];
    logic [32:0] d1_trial  [1:D1_STEPS];
    logic        d1_ge     [1:D1_STEPS];

    // Square stage
    logic           r_u_vld;
    t_side          r_u_side;
    logic [T_W-1:0] r_u_t;
    logic [U_W-1:0] r_u_u;
    logic [60:0]    u_sum;

    // Horner stages
    logic             r_h_vld  [1:H_STEPS];
    t_side            r_h_side [1:H_STEPS];
    logic [T_W-1:0]   r_h_t    [1:H_STEPS];
    logic [U_W-1:0]   r_h_u    [1:H_STEPS];
    logic [ACC_W-1:0] r_h_p    [1:H_STEPS];
    logic [ACC_W-1:0] r_h_q    [1:H_STEPS];
    logic [ACC_W-1:0] n_h_p    [1:H_STEPS];
    logic [ACC_W-1:0] n_h_q    [1:H_STEPS];

    // Ratio divider
    logic             r_d2_vld  [0:D2_STEPS];
    t_side            r_d2_side [0:D2_STEPS];
    logic [T_W-1:0]   r_d2_t    [0:D2_STEPS];
    logic [ACC_W-1:0] r_d2_rem  [0:D2_STEPS];
    logic [29:0]      r_d2_low  [0:D2_STEPS];
    logic [R_W-1:0]   r_d2_quo  [0:D2_STEPS];
    logic [ACC_W-1:0] r_d2_div  [0:D2_STEPS];
    logic [ACC_W-1:0] n_d2_rem  [0:D2_STEPS];
    logic [29:0]      n_d2_low  [0:D2_STEPS];
    logic [R_W-1:0]   n_d2_quo  [0:D2_STEPS];
    logic [ACC_W:0]   d2_trial  [1:D2_STEPS];
    logic             d2_ge     [1:D2_STEPS];
    logic [64:0]      d2_dvd;

    // Kernel product and output
    logic                r_f_vld;
    t_side               r_f_side;
    logic [29:0]         r_f_f;
    logic [60:0]         f_sum;
    logic                r_out_vld;
    logic [ANGLE_W-1:0]  r_out_angle;
    logic [30:0]         mag;

    // Reduction set-up
    logic [31:0] a_n;
    logic [17:0] mid_d;
    logic [16:0] mid_n;
    logic [47:0] d1_dvd;

    function automatic logic [ACC_W-1:0] mul_q30_add(
        input logic [ACC_W-1:0] acc,
        input logic [U_W-1:0]   u,
        input logic [ACC_W-1:0] coef
    );
        logic [63:0] prod;
        logic [64:0] sum;
        prod = 64'(acc) * 64'(u);
        sum  = 65'(prod) + 65'd536870912;
        return ACC_W'(sum[64:30]) + coef;
    endfunction

    assign busy = 1'b0;
    assign a_n  = i_slope[31] ? 32'(~i_slope + 32'd1) : 32'(i_slope);

    // Band selection and dividend/divisor for t
    always_comb begin
        mid_d = 18'(r_in_a) + 18'(ONE_Q16);
        mid_n = (r_in_a < ONE_Q16) ? 17'(ONE_Q16 - r_in_a) : 17'(r_in_a - ONE_Q16);
        n_d1_side[0].neg  = r_in_neg;
        n_d1_side[0].tneg = (r_in_a < ONE_Q16);
        if (r_in_a <= LOW_BAND_MAX) begin
            // t = a << 14 exactly: divide (a << 30) + 2^15 by 2^16
            n_d1_side[0].band = BAND_LOW;
            d1_dvd            = {r_in_a[17:0], 30'd0} + 48'd32768;
            n_d1_div[0]       = ONE_Q16;
        end else if (r_in_a >= HIGH_BAND_MIN) begin
            n_d1_side[0].band = BAND_HIGH;
            d1_dvd            = (48'd1 << 46) + 48'(r_in_a >> 1);
            n_d1_div[0]       = r_in_a;
        end else begin
            n_d1_side[0].band = BAND_MID;
            d1_dvd            = {1'b0, mid_n, 30'd0} + 48'(mid_d >> 1);
            n_d1_div[0]       = 32'(mid_d);
        end
        n_d1_rem[0] = 32'(d1_dvd[47:30]);
        n_d1_low[0] = d1_dvd[29:0];
        n_d1_quo[0] = '0;

        for (int k = 1; k <= D1_STEPS; k++) begin
            d1_trial[k]  = {r_d1_rem[k-1], r_d1_low[k-1][29]};
            d1_ge[k]     = (d1_trial[k] >= {1'b0, r_d1_div[k-1]});
            n_d1_rem[k]  = d1_ge[k] ? 32'(d1_trial[k] - {1'b0, r_d1_div[k-1]})
                                    : d1_trial[k][31:0];
            n_d1_quo[k]  = {r_d1_quo[k-1][28:0], d1_ge[k]};
            n_d1_low[k]  = {r_d1_low[k-1][28:0], 1'b0};
            n_d1_div[k]  = r_d1_div[k-1];
            n_d1_side[k] = r_d1_side[k-1];
        end
    end

    assign u_sum = 61'(60'(r_d1_quo[D1_STEPS]) * 60'(r_d1_quo[D1_STEPS])) + 61'd536870912;

    // Horner: P starts at its leading coefficient, Q is monic
    always_comb begin
        n_h_p[1] = NUM_COEF[0];
        n_h_q[1] = mul_q30_add(ONE_Q24, r_u_u, DEN_COEF[0]);
        for (int k = 2; k <= H_STEPS; k++) begin
            n_h_p[k] = mul_q30_add(r_h_p[k-1], r_h_u[k-1], NUM_COEF[k-1]);
            n_h_q[k] = mul_q30_add(r_h_q[k-1], r_h_u[k-1], DEN_COEF[k-1]);
        end
    end

    // Ratio R = (P << 29 + Q/2) / Q
    always_comb begin
        d2_dvd      = {r_h_p[H_STEPS], 29'd0} + 65'(r_h_q[H_STEPS] >> 1);
        n_d2_rem[0] = ACC_W'(d2_dvd[64:30]);
        n_d2_low[0] = d2_dvd[29:0];
        n_d2_quo[0] = '0;
        for (int k = 1; k <= D2_STEPS; k++) begin
            d2_trial[k] = {r_d2_rem[k-1], r_d2_low[k-1][29]};
            d2_ge[k]    = (d2_trial[k] >= {1'b0, r_d2_div[k-1]});
            n_d2_rem[k] = d2_ge[k] ? ACC_W'(d2_trial[k] - {1'b0, r_d2_div[k-1]})
                                   : d2_trial[k][ACC_W-1:0];
            n_d2_quo[k] = {r_d2_quo[k-1][R_W-2:0], d2_ge[k]};
            n_d2_low[k] = {r_d2_low[k-1][28:0], 1'b0};
        end
    end

    assign f_sum = 61'(60'(r_d2_t[D2_STEPS]) * 60'(r_d2_quo[D2_STEPS])) + 61'd536870912;

    always_comb begin
        case (r_f_side.band)
            BAND_LOW:  mag = 31'(r_f_f);
            BAND_HIGH: mag = 31'(HALF_PI_Q29) - 31'(r_f_f);
            BAND_MID:  mag = r_f_side.tneg ? 31'(QUARTER_PI_Q29) - 31'(r_f_f)
                                           : 31'(QUARTER_PI_Q29) + 31'(r_f_f);
            default:   mag = '0;
        endcase
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_u_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= D1_STEPS; k++) r_d1_vld[k] <= 1'b0;
            for (int k = 1; k <= H_STEPS; k++)  r_h_vld[k]  <= 1'b0;
            for (int k = 0; k <= D2_STEPS; k++) r_d2_vld[k] <= 1'b0;
        end else begin
            r_in_vld    <= start & ~busy;
            r_d1_vld[0] <= r_in_vld;
            for (int k = 1; k <= D1_STEPS; k++) r_d1_vld[k] <= r_d1_vld[k-1];
            r_u_vld     <= r_d1_vld[D1_STEPS];
            r_h_vld[1]  <= r_u_vld;
            for (int k = 2; k <= H_STEPS; k++) r_h_vld[k] <= r_h_vld[k-1];
            r_d2_vld[0] <= r_h_vld[H_STEPS];
            for (int k = 1; k <= D2_STEPS; k++) r_d2_vld[k] <= r_d2_vld[k-1];
            r_f_vld     <= r_d2_vld[D2_STEPS];
            r_out_vld   <= r_f_vld;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_in_neg <= i_slope[31];
        r_in_a   <= a_n;

        for (int k = 0; k <= D1_STEPS; k++) begin
            r_d1_side[k] <= n_d1_side[k];
            r_d1_rem[k]  <= n_d1_rem[k];
            r_d1_low[k]  <= n_d1_low[k];
            r_d1_quo[k]  <= n_d1_quo[k];
            r_d1_div[k]  <= n_d1_div[k];
        end

        r_u_side <= r_d1_side[D1_STEPS];
        r_u_t    <= r_d1_quo[D1_STEPS];
        r_u_u    <= u_sum[57:30];

        r_h_side[1] <= r_u_side;
        r_h_t[1]    <= r_u_t;
        r_h_u[1]    <= r_u_u;
        for (int k = 2; k <= H_STEPS; k++) begin
            r_h_side[k] <= r_h_side[k-1];
            r_h_t[k]    <= r_h_t[k-1];
            r_h_u[k]    <= r_h_u[k-1];
        end
        for (int k = 1; k <= H_STEPS; k++) begin
            r_h_p[k] <= n_h_p[k];
            r_h_q[k] <= n_h_q[k];
        end

        r_d2_side[0] <= r_h_side[H_STEPS];
        r_d2_t[0]    <= r_h_t[H_STEPS];
        r_d2_div[0]  <= r_h_q[H_STEPS];
        for (int k = 1; k <= D2_STEPS; k++) begin
            r_d2_side[k] <= r_d2_side[k-1];
            r_d2_t[k]    <= r_d2_t[k-1];
            r_d2_div[k]  <= r_d2_div[k-1];
        end
        for (int k = 0; k <= D2_STEPS; k++) begin
            r_d2_rem[k] <= n_d2_rem[k];
            r_d2_low[k] <= n_d2_low[k];
            r_d2_quo[k] <= n_d2_quo[k];
        end

        r_f_side <= r_d2_side[D2_STEPS];
        r_f_f    <= f_sum[59:30];

        r_out_angle <= r_f_side.neg ? 31'(-mag) : mag;
    end

    assign o_valid = r_out_vld;
    assign o_angle = r_out_angle;

endmodule

// File: hw/rtl/atan_ra_checker.sv
// ----------------------------------------------------------------------------
// atan_ra_checker
// Port-level checks for the arctangent core: latency, range and sign.
// ----------------------------------------------------------------------------
module atan_ra_checker
    import atan_ra_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic signed [SLOPE_W-1:0] i_slope,
    input logic                      busy,
    input logic                      o_valid,
    input logic signed [ANGLE_W-1:0] o_angle
);

    // Every result strobe traces back to exactly one transfer, fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, ATAN_LAT))
        else $error("result without matching input transfer");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= 31'sd843314857 && o_angle >= -31'sd843314857))
        else $error("angle beyond +/- pi/2");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_slope[31]) |-> ##ATAN_LAT (o_valid && !o_angle[30]))
        else $error("non-negative slope gave negative angle");

    a_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_slope[31]) |-> ##ATAN_LAT (o_valid && o_angle[30]))
        else $error("negative slope gave non-negative angle");

endmodule

bind arctangent_rational_approx_core atan_ra_checker u_atan_ra_checker (.*);
